@@ design/swas_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swas_pkg
// Shared types and constants of the selective-repeat sender window control.
// ============================================================================
package swas_pkg;

    // Window geometry. The slot count must be a power of two so that a slot
    // is the low bits of a sequence number.
    localparam int WINDOW_SLOTS = 64;
    localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);
    localparam int SEQ_BITS     = SLOT_BITS + 1;
    localparam int CNT_BITS     = SEQ_BITS;
    localparam int TIME_BITS    = 16;

    // One slot entry holds the resent flag above the last send time.
    localparam int ENTRY_BITS   = TIME_BITS + 1;

    // Reset value of the resend timeout register.
    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(2);

    // Item kinds.
    typedef enum logic [1:0] {
        ACT_NEW_CHUNK = 2'd0,
        ACT_ACK       = 2'd1,
        ACT_NACK      = 2'd2,
        ACT_TICK      = 2'd3
    } action_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_NACK_EVAL
    } state_t;

    // One result item.
    typedef struct packed {
        logic                send_valid;
        logic [SEQ_BITS-1:0] send_seq;
        logic [SLOT_BITS-1:0] send_slot;
        logic                is_resend;
        logic                window_full;
        logic                ack_accepted;
        logic                transfer_done;
        logic [CNT_BITS-1:0] outstanding_count;
    } result_t;

endpackage

@@ design/swas_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swas_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module swas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sliding_window_arq_sender_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sliding_window_arq_sender_core
// Sender window control for selective-repeat ARQ with per-slot state in RAM.
// ============================================================================
// Usage:
// Items arrive on the s_ channel (action, sequence number, last-chunk flag)
// and each one yields exactly one result item on the m_ channel, held in an
// output register until it is taken.
// New-chunk requests, acks and ticks are decided at acceptance: the result is
// registered and visible in the cycle after, and the next item may follow at
// once while the receiver takes results, so these run at one item per cycle.
// A NACK inside the window reads its slot entry (resent flag and last send
// time) from the slot RAM, whose read port is registered, then decides and,
// only when it resends, writes the entry back; the block takes no new item
// until that result has been loaded into the result register.
// When the receiver stalls, the result register holds and s_ready drops
// until the register can be reloaded; no result is lost.
// The user must write the resend timeout through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. Reset (aresetn low, synchronous)
// empties the window, clears time and the done flag, and sets the timeout to 2.
// Slot entries need no clearing, as every slot is written when its packet is first sent.
// ============================================================================
module sliding_window_arq_sender_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_we,
    input  logic [swas_pkg::TIME_BITS-1:0] cfg_wdata,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [swas_pkg::SEQ_BITS-1:0]  s_seq_number,
    input  logic                           s_last_chunk,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_send_valid,
    output logic [swas_pkg::SEQ_BITS-1:0]  m_send_seq,
    output logic [swas_pkg::SLOT_BITS-1:0] m_send_slot,
    output logic                           m_is_resend,
    output logic                           m_window_full,
    output logic                           m_ack_accepted,
    output logic                           m_transfer_done,
    output logic [swas_pkg::CNT_BITS-1:0]  m_outstanding_count
);

    import swas_pkg::*;

    // Window and control registers.
    state_t               state_reg, state_next;
    logic [SEQ_BITS-1:0]  base_seq_reg, base_seq_next;
    logic [SEQ_BITS-1:0]  next_seq_reg, next_seq_next;
    logic [CNT_BITS-1:0]  in_flight_reg, in_flight_next;
    logic [TIME_BITS-1:0] tick_now_reg, tick_now_next;
    logic                 data_ended_reg, data_ended_next;
    logic [SEQ_BITS-1:0]  final_seq_reg, final_seq_next;
    logic [TIME_BITS-1:0] timeout_reg;
    logic [SEQ_BITS-1:0]  nack_seq_reg, nack_seq_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              res_reg, res_next;

    // Slot RAM interface.
    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ENTRY_BITS-1:0] ram_rdata;

    // Decode helpers.
    action_t              action;
    logic                 s_fire;
    logic                 out_free;
    logic [SEQ_BITS-1:0]  seq_gap;
    logic                 in_window;
    logic                 rd_flag;
    logic [TIME_BITS-1:0] rd_stamp;
    logic [TIME_BITS-1:0] elapsed;
    logic                 nack_send;

    assign action    = action_t'(s_action);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign seq_gap   = s_seq_number - base_seq_reg;
    assign in_window = seq_gap < in_flight_reg;

    // Slot entry read back for a NACK and its resend decision.
    assign rd_flag   = ram_rdata[ENTRY_BITS-1];
    assign rd_stamp  = ram_rdata[TIME_BITS-1:0];
    assign elapsed   = tick_now_reg - rd_stamp;
    assign nack_send = !rd_flag || (elapsed > timeout_reg);

    swas_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (WINDOW_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (s_seq_number[SLOT_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // Next state, window update, slot RAM access and result formation.
    always_comb begin
        state_next      = state_reg;
        base_seq_next   = base_seq_reg;
        next_seq_next   = next_seq_reg;
        in_flight_next  = in_flight_reg;
        tick_now_next   = tick_now_reg;
        data_ended_next = data_ended_reg;
        final_seq_next  = final_seq_reg;
        nack_seq_next   = nack_seq_reg;
        ram_we          = 1'b0;
        ram_waddr       = next_seq_reg[SLOT_BITS-1:0];
        ram_wdata       = {1'b0, tick_now_reg};
        ram_re          = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        res_next        = res_reg;

        // Fields that every result shares, filled in again below.
        res_next.send_valid   = 1'b0;
        res_next.send_seq     = '0;
        res_next.send_slot    = '0;
        res_next.is_resend    = 1'b0;
        res_next.window_full  = 1'b0;
        res_next.ack_accepted = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_valid_next = 1'b1;
                    case (action)
                        ACT_NEW_CHUNK: begin
                            if (!data_ended_reg) begin
                                if (in_flight_reg >= CNT_BITS'(WINDOW_SLOTS)) begin
                                    res_next.window_full = 1'b1;
                                end else begin
                                    // First send clears the resent flag and stamps the slot.
                                    ram_we             = 1'b1;
                                    res_next.send_valid = 1'b1;
                                    res_next.send_seq  = next_seq_reg;
                                    res_next.send_slot = next_seq_reg[SLOT_BITS-1:0];
                                    if (s_last_chunk) begin
                                        data_ended_next = 1'b1;
                                        final_seq_next  = next_seq_reg;
                                    end
                                    next_seq_next  = next_seq_reg + SEQ_BITS'(1);
                                    in_flight_next = in_flight_reg + CNT_BITS'(1);
                                end
                            end
                        end
                        ACT_ACK: begin
                            // The ack covers everything up to and including its number.
                            if (in_window) begin
                                res_next.ack_accepted = 1'b1;
                                base_seq_next  = s_seq_number + SEQ_BITS'(1);
                                in_flight_next = in_flight_reg - CNT_BITS'(seq_gap)
                                                 - CNT_BITS'(1);
                            end
                        end
                        ACT_NACK: begin
                            // An outstanding NACK needs its slot entry first.
                            if (in_window) begin
                                ram_re        = 1'b1;
                                nack_seq_next = s_seq_number;
                                m_valid_next  = 1'b0;
                                state_next    = ST_NACK_EVAL;
                            end
                        end
                        ACT_TICK: begin
                            tick_now_next = tick_now_reg + TIME_BITS'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NACK_EVAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (nack_send) begin
                        ram_we             = 1'b1;
                        ram_waddr          = nack_seq_reg[SLOT_BITS-1:0];
                        ram_wdata          = {1'b1, tick_now_reg};
                        res_next.send_valid = 1'b1;
                        res_next.is_resend = 1'b1;
                        res_next.send_seq  = nack_seq_reg;
                        res_next.send_slot = nack_seq_reg[SLOT_BITS-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.transfer_done     = data_ended_next && (in_flight_next == '0);
        res_next.outstanding_count = in_flight_next;

        // Keep the held result while it waits to be taken.
        if (!m_valid_next || (m_valid_reg && !m_ready)) begin
            res_next = res_reg;
        end
    end

    // Control and window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_seq_reg   <= '0;
            next_seq_reg   <= '0;
            in_flight_reg  <= '0;
            tick_now_reg   <= '0;
            data_ended_reg <= 1'b0;
            final_seq_reg  <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_seq_reg   <= base_seq_next;
            next_seq_reg   <= next_seq_next;
            in_flight_reg  <= in_flight_next;
            tick_now_reg   <= tick_now_next;
            data_ended_reg <= data_ended_next;
            final_seq_reg  <= final_seq_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        nack_seq_reg <= nack_seq_next;
        res_reg      <= res_next;
    end

    // Result channel.
    assign m_valid             = m_valid_reg;
    assign m_send_valid        = res_reg.send_valid;
    assign m_send_seq          = res_reg.send_seq;
    assign m_send_slot         = res_reg.send_slot;
    assign m_is_resend         = res_reg.is_resend;
    assign m_window_full       = res_reg.window_full;
    assign m_ack_accepted      = res_reg.ack_accepted;
    assign m_transfer_done     = res_reg.transfer_done;
    assign m_outstanding_count = res_reg.outstanding_count;

endmodule
